// ===== rtl/box_sum_threshold_macros.svh =====
// Assertion shorthands shared by the box sum blocks.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef BOX_SUM_THRESHOLD_MACROS_SVH
`define BOX_SUM_THRESHOLD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BST_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bst_pkg.sv =====
package bst_pkg;

    // Storage limits.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_BLOCK  = 16;
    localparam int MAX_HEIGHT = 2048;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int CS_W       = 12;
    localparam int WS_W       = 16;
    localparam int ANCHOR_W   = 11;
    localparam int THR_W      = 16;
    localparam int BSZ_W      = 5;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Widths derived from the limits.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int HCNT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W  = $clog2(MAX_BLOCK);
    localparam int BCNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int HIST_AW = SLOT_W + COL_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_THRESHOLD = 2'd3;

    // Input pixel transaction.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_start;
    } bst_in_t;

    // Output anchor transaction.
    typedef struct packed {
        logic [ANCHOR_W-1:0] anchor_row;
        logic [ANCHOR_W-1:0] anchor_col;
        logic                above_threshold;
    } bst_out_t;

    // One accepted pixel, decoded against the raster position.
    typedef struct packed {
        logic [PIX_W-1:0]    pix;
        logic [COL_W-1:0]    col;
        logic [COL_W-1:0]    colb;
        logic [HIST_AW-1:0]  hidx;
        logic                col_first;
        logic                col_ge_b;
        logic                cs_valid;
        logic                hist_sub;
        logic                emit;
        logic [ANCHOR_W-1:0] anchor_row;
        logic [ANCHOR_W-1:0] anchor_col;
    } bst_item_t;

    // Write-back to the column sum and row history memories.
    typedef struct packed {
        logic               we;
        logic [COL_W-1:0]   col;
        logic [CS_W-1:0]    cs;
        logic [HIST_AW-1:0] hidx;
        logic [PIX_W-1:0]   pix;
    } bst_wr_t;

    // Row slot reload from the remainder unit.
    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] slot;
    } bst_slot_ld_t;

endpackage

// ===== rtl/bst_ram.sv =====
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bst_slot_div.sv =====
`include "box_sum_threshold_macros.svh"

module bst_slot_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bst_pkg::ROW_W-1:0]    row,
    input  logic [bst_pkg::BCNT_W-1:0]   blk,
    output logic                         busy,
    output bst_pkg::bst_slot_ld_t        slot_ld
);

    import bst_pkg::*;

    localparam int IDX_W = $clog2(ROW_W);

    logic              busy_reg, busy_next;
    logic              ld_reg, ld_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]  dvd_reg, dvd_next;
    logic [BCNT_W-1:0] rem_reg, rem_next;
    logic [BCNT_W-1:0] blk_reg, blk_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [BCNT_W:0]   trial;

    // Restoring remainder, one row bit per cycle, most significant bit first.
    always_comb
    begin
        busy_next = busy_reg;
        ld_next   = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        blk_next  = blk_reg;
        slot_next = slot_reg;
        trial     = {rem_reg, dvd_reg[ROW_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = IDX_W'(ROW_W - 1);
            dvd_next  = row;
            rem_next  = '0;
            blk_next  = blk;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, blk_reg})
            begin
                rem_next = BCNT_W'(trial - {1'b0, blk_reg});
            end
            else
            begin
                rem_next = BCNT_W'(trial);
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - IDX_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                ld_next   = 1'b1;
                slot_next = SLOT_W'(rem_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ld_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ld_reg   <= ld_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        blk_reg  <= blk_next;
        slot_reg <= slot_next;
    end

    // Busy covers the load cycle so no pixel races the slot reload.
    assign busy         = busy_reg || ld_reg;
    assign slot_ld.load = ld_reg;
    assign slot_ld.slot = slot_reg;

    `BST_ASSERT_NEXT(a_div_start_busy, start, busy, "remainder unit did not start")

endmodule

// ===== rtl/bst_raster.sv =====
`include "box_sum_threshold_macros.svh"

module bst_raster (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        acc,
    input  bst_pkg::bst_in_t            px,
    input  logic [bst_pkg::BCNT_W-1:0]  blk,
    input  logic [bst_pkg::WCNT_W-1:0]  wid,
    input  logic [bst_pkg::HCNT_W-1:0]  hgt,
    input  bst_pkg::bst_slot_ld_t       slot_ld,
    output bst_pkg::bst_item_t          item,
    output logic [bst_pkg::ROW_W-1:0]   row
);

    import bst_pkg::*;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WCNT_W-1:0] ext_reg, ext_next;

    logic              clr;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic [SLOT_W-1:0] slot;
    logic [WCNT_W-1:0] ext;
    logic [WCNT_W-1:0] c1;
    logic [HCNT_W-1:0] r1;
    logic [WCNT_W-1:0] ext_grow;
    logic [BCNT_W-1:0] slot_inc;

    // Position of this pixel; a frame start or a stale position restarts the frame.
    always_comb
    begin
        clr = px.frame_start || (WCNT_W'(col_reg) >= wid) || (HCNT_W'(row_reg) >= hgt);
        r        = clr ? '0 : row_reg;
        c        = clr ? '0 : col_reg;
        slot     = clr ? '0 : slot_reg;
        ext      = clr ? '0 : ext_reg;
        c1       = WCNT_W'(c) + WCNT_W'(1);
        r1       = HCNT_W'(r) + HCNT_W'(1);
        ext_grow = (c1 > ext) ? c1 : ext;
        slot_inc = BCNT_W'(slot) + BCNT_W'(1);
    end

    // Decode of the pixel for the sum stage.
    always_comb
    begin
        item.pix        = px.pixel_value;
        item.col        = c;
        item.colb       = COL_W'(WCNT_W'(c) - WCNT_W'(blk));
        item.hidx       = {slot, c};
        item.col_first  = (c == '0);
        item.col_ge_b   = (WCNT_W'(c) >= WCNT_W'(blk));
        item.cs_valid   = (WCNT_W'(c) < ext);
        item.hist_sub   = (HCNT_W'(r) >= HCNT_W'(blk));
        item.emit       = (r1 >= HCNT_W'(blk)) && (c1 >= WCNT_W'(blk))
                          && (hgt > HCNT_W'(blk)) && (wid > WCNT_W'(blk))
                          && (r1 < hgt) && (c1 < wid);
        item.anchor_row = ANCHOR_W'(r1 - HCNT_W'(blk));
        item.anchor_col = ANCHOR_W'(c1 - WCNT_W'(blk));
    end

    // Raster advance: next column, next row, or wrap to a fresh frame; with no pixel, a row slot reload.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        ext_next  = ext_reg;
        if (acc)
        begin
            if (c1 >= wid)
            begin
                col_next = '0;
                if (r1 >= hgt)
                begin
                    row_next  = '0;
                    slot_next = '0;
                    ext_next  = '0;
                end
                else
                begin
                    row_next  = ROW_W'(r1);
                    slot_next = (slot_inc >= blk) ? '0 : SLOT_W'(slot_inc);
                    ext_next  = ext_grow;
                end
            end
            else
            begin
                col_next  = COL_W'(c1);
                row_next  = r;
                slot_next = slot;
                ext_next  = ext_grow;
            end
        end
        else if (slot_ld.load)
        begin
            slot_next = slot_ld.slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            ext_reg  <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            ext_reg  <= ext_next;
        end
    end

    assign row = row_reg;

    // Every column left of the current one has been summed in this frame.
    `BST_ASSERT_SAME(a_ext_covers_col, 1'b1, WCNT_W'(col_reg) <= ext_reg,
        "column position ran past the written column range")

endmodule

// ===== rtl/bst_sum.sv =====
`include "box_sum_threshold_macros.svh"

module bst_sum (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         acc,
    input  bst_pkg::bst_item_t           item,
    input  logic [bst_pkg::CS_W-1:0]     cs_q_a,
    input  logic [bst_pkg::CS_W-1:0]     cs_q_b,
    input  logic [bst_pkg::PIX_W-1:0]    hist_q,
    input  logic [bst_pkg::THR_W-1:0]    thr,
    output logic                         s1_ready,
    output bst_pkg::bst_wr_t             wr,
    output logic                         out_valid,
    input  logic                         out_ready,
    output bst_pkg::bst_out_t            out_data
);

    import bst_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    bst_item_t        s1_item_reg;
    logic             fwd_a_reg, fwd_b_reg, fwd_h_reg;
    logic [CS_W-1:0]  last_cs_reg;
    logic [PIX_W-1:0] last_pix_reg;
    logic [WS_W-1:0]  ws_reg;
    logic             out_valid_reg, out_valid_next;
    bst_out_t         out_reg;

    logic             s1_fire;
    logic [CS_W-1:0]  cs_old, cs_base, hist_drop, cs_new, cs_left;
    logic [PIX_W-1:0] hist_old;
    logic [WS_W-1:0]  ws_base, ws_drop, ws_new;

    // A pixel with no anchor leaves even while the output register is full.
    assign s1_fire  = s1_valid_reg
                      && (!s1_item_reg.emit || !out_valid_reg || out_ready);
    assign s1_ready = !s1_valid_reg || s1_fire;

    // Vertical and horizontal running sums, with bypass of the previous write.
    always_comb
    begin
        cs_old    = fwd_a_reg ? last_cs_reg : cs_q_a;
        cs_base   = s1_item_reg.cs_valid ? cs_old : '0;
        hist_old  = fwd_h_reg ? last_pix_reg : hist_q;
        hist_drop = s1_item_reg.hist_sub ? CS_W'(hist_old) : '0;
        cs_new    = cs_base - hist_drop + CS_W'(s1_item_reg.pix);
        cs_left   = fwd_b_reg ? last_cs_reg : cs_q_b;
        ws_base   = s1_item_reg.col_first ? '0 : ws_reg;
        ws_drop   = s1_item_reg.col_ge_b ? WS_W'(cs_left) : '0;
        ws_new    = ws_base + WS_W'(cs_new) - ws_drop;
    end

    // Memory write-back when the pixel leaves the stage.
    always_comb
    begin
        wr.we   = s1_fire;
        wr.col  = s1_item_reg.col;
        wr.cs   = cs_new;
        wr.hidx = s1_item_reg.hidx;
        wr.pix  = s1_item_reg.pix;
    end

    // Stage and output register occupancy.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_item_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ws_reg        <= '0;
            fwd_a_reg     <= 1'b0;
            fwd_b_reg     <= 1'b0;
            fwd_h_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                ws_reg <= ws_new;
            end
            if (acc)
            begin
                fwd_a_reg <= s1_fire && (s1_item_reg.col == item.col);
                fwd_b_reg <= s1_fire && (s1_item_reg.col == item.colb);
                fwd_h_reg <= s1_fire && (s1_item_reg.hidx == item.hidx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_item_reg <= item;
        end
        if (s1_fire)
        begin
            last_cs_reg  <= cs_new;
            last_pix_reg <= s1_item_reg.pix;
        end
        if (s1_fire && s1_item_reg.emit)
        begin
            out_reg.anchor_row      <= s1_item_reg.anchor_row;
            out_reg.anchor_col      <= s1_item_reg.anchor_col;
            out_reg.above_threshold <= (ws_new > thr);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `BST_ASSERT_SAME(a_no_overrun, acc, !s1_valid_reg || s1_fire,
        "new pixel overwrote one still held in the sum stage")
    `BST_ASSERT_NEXT(a_emit_lands, s1_fire && s1_item_reg.emit, out_valid_reg,
        "anchor left the sum stage without reaching the output register")

endmodule

// ===== rtl/box_sum_threshold.sv =====
// Channel  | Handshake                 | Payload
// pixel    | pixel_valid, pixel_ready  | pixel (pixel_value, frame_start)
// anchor   | anchor_valid, anchor_ready| anchor (anchor_row, anchor_col, above_threshold)
// cfg      | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One pixel per cycle while pixel_ready is high; anchor_valid is registered.
// The rate is set by the column sum read-modify-write, which completes every cycle
// with a bypass of the previous write around the registered memory reads.
// A write to block_size holds pixel_ready low while the row slot
// is recomputed by a one-bit-per-cycle remainder unit over the 11-bit row.
// A stalled anchor channel stalls pixels only when the pending pixel has an anchor.
// Reset is asynchronous, active low; no memory clearing pass is needed.
`include "box_sum_threshold_macros.svh"

module box_sum_threshold (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  bst_pkg::bst_in_t                 pixel,
    output logic                             anchor_valid,
    input  logic                             anchor_ready,
    output bst_pkg::bst_out_t                anchor,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bst_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import bst_pkg::*;

    logic [BSZ_W-1:0]  block_size_reg;
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [THR_W-1:0]  sum_threshold_reg;
    logic              div_start_reg;

    logic              cfg_fire;
    logic              pixel_fire;
    logic [BCNT_W-1:0] blk;
    logic [WCNT_W-1:0] wid;
    logic [HCNT_W-1:0] hgt;
    logic              s1_ready;
    logic              div_busy;
    bst_slot_ld_t      slot_ld;
    bst_item_t         item;
    bst_wr_t           wr;
    logic [ROW_W-1:0]  row;
    logic [CS_W-1:0]   cs_q_a, cs_q_b;
    logic [PIX_W-1:0]  hist_q;

    function automatic logic [BCNT_W-1:0] clamp_block(input logic [BSZ_W-1:0] v);
        if (v == '0)
        begin
            return BCNT_W'(1);
        end
        if (32'(v) > MAX_BLOCK)
        begin
            return BCNT_W'(MAX_BLOCK);
        end
        return BCNT_W'(v);
    endfunction

    function automatic logic [WCNT_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return WCNT_W'(1);
        end
        if (32'(v) > MAX_WIDTH)
        begin
            return WCNT_W'(MAX_WIDTH);
        end
        return WCNT_W'(v);
    endfunction

    function automatic logic [HCNT_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return HCNT_W'(1);
        end
        if (32'(v) > MAX_HEIGHT)
        begin
            return HCNT_W'(MAX_HEIGHT);
        end
        return HCNT_W'(v);
    endfunction

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg    <= BSZ_W'(5);
            frame_width_reg   <= DIM_W'(640);
            frame_height_reg  <= DIM_W'(480);
            sum_threshold_reg <= '0;
            div_start_reg     <= 1'b0;
        end
        else
        begin
            div_start_reg <= cfg_fire && (cfg_index == CFG_BLOCK_SIZE);
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_BLOCK_SIZE:    block_size_reg    <= cfg_data[BSZ_W-1:0];
                    CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[DIM_W-1:0];
                    CFG_SUM_THRESHOLD: sum_threshold_reg <= cfg_data[THR_W-1:0];
                    default:           sum_threshold_reg <= sum_threshold_reg;
                endcase
            end
        end
    end

    // Effective geometry after clamping.
    assign blk = clamp_block(block_size_reg);
    assign wid = clamp_width(frame_width_reg);
    assign hgt = clamp_height(frame_height_reg);

    assign pixel_ready = s1_ready && !div_busy && !div_start_reg;
    assign pixel_fire  = pixel_valid && pixel_ready;

    // Row slot recompute after a window size change.
    bst_slot_div u_slot_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start_reg),
        .row     (row),
        .blk     (blk),
        .busy    (div_busy),
        .slot_ld (slot_ld)
    );

    // Raster position tracking and pixel decode.
    bst_raster u_raster (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (pixel_fire),
        .px      (pixel),
        .blk     (blk),
        .wid     (wid),
        .hgt     (hgt),
        .slot_ld (slot_ld),
        .item    (item),
        .row     (row)
    );

    // Column sums, kept in two copies for the two read columns.
    bst_ram #(
        .WIDTH (CS_W),
        .DEPTH (MAX_WIDTH)
    ) u_cs_a (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.col),
        .wdata (wr.cs),
        .re    (pixel_fire),
        .raddr (item.col),
        .rdata (cs_q_a)
    );

    bst_ram #(
        .WIDTH (CS_W),
        .DEPTH (MAX_WIDTH)
    ) u_cs_b (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.col),
        .wdata (wr.cs),
        .re    (pixel_fire),
        .raddr (item.colb),
        .rdata (cs_q_b)
    );

    // Last block_size rows of pixels, one slot per row.
    bst_ram #(
        .WIDTH (PIX_W),
        .DEPTH (2 ** HIST_AW)
    ) u_hist (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.hidx),
        .wdata (wr.pix),
        .re    (pixel_fire),
        .raddr (item.hidx),
        .rdata (hist_q)
    );

    // Sum stage and anchor output register.
    bst_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (pixel_fire),
        .item      (item),
        .cs_q_a    (cs_q_a),
        .cs_q_b    (cs_q_b),
        .hist_q    (hist_q),
        .thr       (sum_threshold_reg),
        .s1_ready  (s1_ready),
        .wr        (wr),
        .out_valid (anchor_valid),
        .out_ready (anchor_ready),
        .out_data  (anchor)
    );

    `BST_ASSERT_SAME(a_no_pixel_in_reload, div_busy || div_start_reg, !pixel_fire,
        "pixel accepted while the row slot was being recomputed")

endmodule
